FILE: src/vec3_axis_rotation_defines.svh
// assertion macros for the rotation block checker
`ifndef VEC3_AXIS_ROTATION_DEFINES_SVH
`define VEC3_AXIS_ROTATION_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VEC3R_ASSERT_NOW(name, ant, con) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("vec3r check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VEC3R_ASSERT_NEXT(name, ant, con) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("vec3r check failed");

`endif

FILE: src/vec3r_pkg.sv
// shared types, constants and sine table builder for the rotation block
package vec3r_pkg;

  typedef enum logic [1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_PASS  = 2'd3
  } op_e;

  localparam int ANGLE_BITS = 16;
  localparam int TRIG_BITS  = 16;
  localparam int MAG_BITS   = 15;
  localparam int FRAC_SHIFT = 15;
  localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
  localparam int OP_BITS    = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // one taylor step: divide by (2n)(2n+1)
  function automatic logic [63:0] series_div(logic [63:0] term, int n);
    case (n)
      1:       return term / 64'd6;
      2:       return term / 64'd20;
      3:       return term / 64'd42;
      4:       return term / 64'd72;
      5:       return term / 64'd110;
      6:       return term / 64'd156;
      7:       return term / 64'd210;
      8:       return term / 64'd272;
      9:       return term / 64'd342;
      10:      return term / 64'd420;
      11:      return term / 64'd506;
      12:      return term / 64'd600;
      13:      return term / 64'd702;
      14:      return term / 64'd812;
      15:      return term / 64'd930;
      16:      return term / 64'd1056;
      17:      return term / 64'd1190;
      18:      return term / 64'd1332;
      19:      return term / 64'd1482;
      default: return 64'd0;
    endcase
  endfunction

  // quarter-wave q0.15 table entry k for 2**index_bits steps per quarter
  function automatic logic [MAG_BITS-1:0] sine_entry(int k, int index_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic signed [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) >> index_bits;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n < 20; n++) begin
      if (term != 64'd0) begin
        term = series_div((term * x2) >> 30, n);
        if ((n & 1) != 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return MAG_BITS'(v);
  endfunction

endpackage

FILE: src/vec3r_trig.sv
// first stage: sine and cosine lookup and operand selection
module vec3r_trig #(
  parameter int COORD_WIDTH     = 32,
  parameter int SINE_INDEX_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  vec3r_pkg::op_e                       op_i,
  input  logic signed [COORD_WIDTH-1:0]        x_i,
  input  logic signed [COORD_WIDTH-1:0]        y_i,
  input  logic signed [COORD_WIDTH-1:0]        z_i,
  input  logic [vec3r_pkg::ANGLE_BITS-1:0]     angle_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output vec3r_pkg::op_e                       op_o,
  output logic signed [COORD_WIDTH-1:0]        x_o,
  output logic signed [COORD_WIDTH-1:0]        y_o,
  output logic signed [COORD_WIDTH-1:0]        z_o,
  output logic signed [COORD_WIDTH-1:0]        a_o,
  output logic signed [COORD_WIDTH-1:0]        b_o,
  output logic [vec3r_pkg::MAG_BITS-1:0]       sin_mag_o,
  output logic [vec3r_pkg::MAG_BITS-1:0]       cos_mag_o,
  output logic                                 sin_neg_o,
  output logic                                 cos_neg_o
);

  localparam int Steps     = 1 << SINE_INDEX_BITS;
  localparam int PhaseBits = SINE_INDEX_BITS + 2;
  localparam int RomIdxW   = SINE_INDEX_BITS + 1;

  logic [vec3r_pkg::MAG_BITS-1:0] rom [Steps+1];

  for (genvar k = 0; k <= Steps; k++) begin : g_rom
    assign rom[k] = vec3r_pkg::sine_entry(k, SINE_INDEX_BITS);
  end

  logic [PhaseBits-1:0]       phase;
  logic [1:0]                 quad;
  logic [RomIdxW-1:0]         fidx;
  logic [RomIdxW-1:0]         ridx;
  logic [vec3r_pkg::MAG_BITS-1:0] fwd_mag;
  logic [vec3r_pkg::MAG_BITS-1:0] rev_mag;
  logic signed [COORD_WIDTH-1:0]  a_sel;
  logic signed [COORD_WIDTH-1:0]  b_sel;

  logic valid_q;

  assign phase   = angle_i[vec3r_pkg::ANGLE_BITS-1 -: PhaseBits];
  assign quad    = phase[PhaseBits-1 -: 2];
  assign fidx    = {1'b0, phase[SINE_INDEX_BITS-1:0]};
  assign ridx    = RomIdxW'(Steps) - fidx;
  assign fwd_mag = rom[fidx];
  assign rev_mag = rom[ridx];

  always_comb begin
    case (op_i)
      vec3r_pkg::OP_ROT_X: begin
        a_sel = y_i;
        b_sel = z_i;
      end
      vec3r_pkg::OP_ROT_Y: begin
        a_sel = x_i;
        b_sel = z_i;
      end
      default: begin
        a_sel = x_i;
        b_sel = y_i;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_o      <= op_i;
      x_o       <= x_i;
      y_o       <= y_i;
      z_o       <= z_i;
      a_o       <= a_sel;
      b_o       <= b_sel;
      sin_mag_o <= quad[0] ? rev_mag : fwd_mag;
      cos_mag_o <= quad[0] ? fwd_mag : rev_mag;
      sin_neg_o <= quad[1];
      cos_neg_o <= quad[1] ^ quad[0];
    end
  end

endmodule

FILE: src/vec3r_mult.sv
// second stage: four coordinate by trig products
module vec3r_mult #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  vec3r_pkg::op_e                                op_i,
  input  logic signed [COORD_WIDTH-1:0]                 x_i,
  input  logic signed [COORD_WIDTH-1:0]                 y_i,
  input  logic signed [COORD_WIDTH-1:0]                 z_i,
  input  logic signed [COORD_WIDTH-1:0]                 a_i,
  input  logic signed [COORD_WIDTH-1:0]                 b_i,
  input  logic [vec3r_pkg::MAG_BITS-1:0]                sin_mag_i,
  input  logic [vec3r_pkg::MAG_BITS-1:0]                cos_mag_i,
  input  logic                                          sin_neg_i,
  input  logic                                          cos_neg_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output vec3r_pkg::op_e                                op_o,
  output logic signed [COORD_WIDTH-1:0]                 x_o,
  output logic signed [COORD_WIDTH-1:0]                 y_o,
  output logic signed [COORD_WIDTH-1:0]                 z_o,
  output logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] ac_o,
  output logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] bs_o,
  output logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] as_o,
  output logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] bc_o
);

  localparam int ProdW = COORD_WIDTH + vec3r_pkg::TRIG_BITS;

  logic signed [vec3r_pkg::TRIG_BITS-1:0] sin_v;
  logic signed [vec3r_pkg::TRIG_BITS-1:0] cos_v;
  logic signed [vec3r_pkg::TRIG_BITS-1:0] sin_pos;
  logic signed [vec3r_pkg::TRIG_BITS-1:0] cos_pos;

  logic valid_q;

  assign sin_pos = $signed({1'b0, sin_mag_i});
  assign cos_pos = $signed({1'b0, cos_mag_i});
  assign sin_v   = sin_neg_i ? -sin_pos : sin_pos;
  assign cos_v   = cos_neg_i ? -cos_pos : cos_pos;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_o <= op_i;
      x_o  <= x_i;
      y_o  <= y_i;
      z_o  <= z_i;
      ac_o <= ProdW'(a_i) * ProdW'(cos_v);
      bs_o <= ProdW'(b_i) * ProdW'(sin_v);
      as_o <= ProdW'(a_i) * ProdW'(sin_v);
      bc_o <= ProdW'(b_i) * ProdW'(cos_v);
    end
  end

endmodule

FILE: src/vec3r_sum.sv
// third stage: rounding, add or subtract, saturation and output routing
module vec3r_sum #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  output logic                                               ready_o,
  input  vec3r_pkg::op_e                                     op_i,
  input  logic signed [COORD_WIDTH-1:0]                      x_i,
  input  logic signed [COORD_WIDTH-1:0]                      y_i,
  input  logic signed [COORD_WIDTH-1:0]                      z_i,
  input  logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] ac_i,
  input  logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] bs_i,
  input  logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] as_i,
  input  logic signed [COORD_WIDTH+vec3r_pkg::TRIG_BITS-1:0] bc_i,
  output logic                                               valid_o,
  input  logic                                               ready_i,
  output logic signed [COORD_WIDTH-1:0]                      x_o,
  output logic signed [COORD_WIDTH-1:0]                      y_o,
  output logic signed [COORD_WIDTH-1:0]                      z_o
);

  localparam int ProdW = COORD_WIDTH + vec3r_pkg::TRIG_BITS;
  localparam int RndW  = COORD_WIDTH + 1;
  localparam int SumW  = COORD_WIDTH + 2;

  localparam logic signed [ProdW-1:0] RoundAdd = ProdW'(vec3r_pkg::ROUND_HALF);
  localparam logic [COORD_WIDTH-1:0] SatMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SatMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [ProdW-1:0]       ac_r;
  logic signed [ProdW-1:0]       bs_r;
  logic signed [ProdW-1:0]       as_r;
  logic signed [ProdW-1:0]       bc_r;
  logic signed [RndW-1:0]        ac_p;
  logic signed [RndW-1:0]        bs_p;
  logic signed [RndW-1:0]        as_p;
  logic signed [RndW-1:0]        bc_p;
  logic signed [SumW-1:0]        diff;
  logic signed [SumW-1:0]        total;
  logic signed [COORD_WIDTH-1:0] first_sat;
  logic signed [COORD_WIDTH-1:0] second_sat;
  logic signed [COORD_WIDTH-1:0] x_d;
  logic signed [COORD_WIDTH-1:0] y_d;
  logic signed [COORD_WIDTH-1:0] z_d;

  logic valid_q;

  // round half up, then drop the fraction
  assign ac_r = ac_i + RoundAdd;
  assign bs_r = bs_i + RoundAdd;
  assign as_r = as_i + RoundAdd;
  assign bc_r = bc_i + RoundAdd;
  assign ac_p = ac_r[ProdW-1 -: RndW];
  assign bs_p = bs_r[ProdW-1 -: RndW];
  assign as_p = as_r[ProdW-1 -: RndW];
  assign bc_p = bc_r[ProdW-1 -: RndW];

  assign diff  = SumW'(ac_p) - SumW'(bs_p);
  assign total = SumW'(as_p) + SumW'(bc_p);

  always_comb begin
    if (diff[SumW-1:COORD_WIDTH-1] == '0 || diff[SumW-1:COORD_WIDTH-1] == '1) begin
      first_sat = diff[COORD_WIDTH-1:0];
    end else begin
      first_sat = diff[SumW-1] ? SatMin : SatMax;
    end
    if (total[SumW-1:COORD_WIDTH-1] == '0 || total[SumW-1:COORD_WIDTH-1] == '1) begin
      second_sat = total[COORD_WIDTH-1:0];
    end else begin
      second_sat = total[SumW-1] ? SatMin : SatMax;
    end
  end

  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    case (op_i)
      vec3r_pkg::OP_ROT_X: begin
        y_d = first_sat;
        z_d = second_sat;
      end
      vec3r_pkg::OP_ROT_Y: begin
        x_d = first_sat;
        z_d = second_sat;
      end
      vec3r_pkg::OP_ROT_Z: begin
        x_d = first_sat;
        y_d = second_sat;
      end
      default: begin
        x_d = x_i;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

FILE: src/vec3_axis_rotation.sv
// top level of the principal-axis point rotation pipeline
//
// rotates one signed fixed-point 3d point about the x, y or z axis.
// input stream: tdata carries x, y, z and the binary turn angle, tuser the
// axis selector (0 x, 1 y, 2 z, 3 pass the point through unchanged).
// output stream: tdata carries the rotated x, y, z, saturated to the
// coordinate range; the untouched axis is passed through as given.
// an input transfer reaches the output through the three register stages
// (table lookup, products, round and sum), any of which can hold it on a stall.
// throughput: one transfer per cycle, sustained while the receiver takes
// results; each stage holds its item while the next stage is full.
// every transfer in gives exactly one transfer out, in order.
// reset clears all stage valid bits; no output is valid after reset.
// when the receiver stalls, the output is held stable and the stages fill
// up behind it; s_axis_tready falls only when every stage is occupied.
// the sine table is constant logic, read twice per item for sine and cosine.
module vec3_axis_rotation #(
  parameter int COORD_WIDTH     = 32,
  parameter int SINE_INDEX_BITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // x_in, y_in, z_in, turn_angle, zero fill
  input  logic [((3*COORD_WIDTH+vec3r_pkg::ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic [vec3r_pkg::OP_BITS-1:0]            s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // x_out, y_out, z_out, zero fill
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);

  localparam int ProdW    = COORD_WIDTH + vec3r_pkg::TRIG_BITS;
  localparam int MDataW   = ((3*COORD_WIDTH+7)/8)*8;
  localparam int MPadW    = MDataW - 3*COORD_WIDTH;

  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [COORD_WIDTH-1:0] z_in;
  logic [vec3r_pkg::ANGLE_BITS-1:0] turn_angle;

  logic                              t_valid;
  logic                              t_ready;
  vec3r_pkg::op_e                    t_op;
  logic signed [COORD_WIDTH-1:0]     t_x;
  logic signed [COORD_WIDTH-1:0]     t_y;
  logic signed [COORD_WIDTH-1:0]     t_z;
  logic signed [COORD_WIDTH-1:0]     t_a;
  logic signed [COORD_WIDTH-1:0]     t_b;
  logic [vec3r_pkg::MAG_BITS-1:0]    t_sin_mag;
  logic [vec3r_pkg::MAG_BITS-1:0]    t_cos_mag;
  logic                              t_sin_neg;
  logic                              t_cos_neg;

  logic                              p_valid;
  logic                              p_ready;
  vec3r_pkg::op_e                    p_op;
  logic signed [COORD_WIDTH-1:0]     p_x;
  logic signed [COORD_WIDTH-1:0]     p_y;
  logic signed [COORD_WIDTH-1:0]     p_z;
  logic signed [ProdW-1:0]           p_ac;
  logic signed [ProdW-1:0]           p_bs;
  logic signed [ProdW-1:0]           p_as;
  logic signed [ProdW-1:0]           p_bc;

  logic signed [COORD_WIDTH-1:0]     x_out;
  logic signed [COORD_WIDTH-1:0]     y_out;
  logic signed [COORD_WIDTH-1:0]     z_out;

  assign x_in       = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
  assign y_in       = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
  assign z_in       = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign turn_angle = s_axis_tdata[3*COORD_WIDTH +: vec3r_pkg::ANGLE_BITS];

  vec3r_trig #(
    .COORD_WIDTH    (COORD_WIDTH),
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_trig (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .op_i     (vec3r_pkg::op_e'(s_axis_tuser)),
    .x_i      (x_in),
    .y_i      (y_in),
    .z_i      (z_in),
    .angle_i  (turn_angle),
    .valid_o  (t_valid),
    .ready_i  (t_ready),
    .op_o     (t_op),
    .x_o      (t_x),
    .y_o      (t_y),
    .z_o      (t_z),
    .a_o      (t_a),
    .b_o      (t_b),
    .sin_mag_o(t_sin_mag),
    .cos_mag_o(t_cos_mag),
    .sin_neg_o(t_sin_neg),
    .cos_neg_o(t_cos_neg)
  );

  vec3r_mult #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (t_valid),
    .ready_o  (t_ready),
    .op_i     (t_op),
    .x_i      (t_x),
    .y_i      (t_y),
    .z_i      (t_z),
    .a_i      (t_a),
    .b_i      (t_b),
    .sin_mag_i(t_sin_mag),
    .cos_mag_i(t_cos_mag),
    .sin_neg_i(t_sin_neg),
    .cos_neg_i(t_cos_neg),
    .valid_o  (p_valid),
    .ready_i  (p_ready),
    .op_o     (p_op),
    .x_o      (p_x),
    .y_o      (p_y),
    .z_o      (p_z),
    .ac_o     (p_ac),
    .bs_o     (p_bs),
    .as_o     (p_as),
    .bc_o     (p_bc)
  );

  vec3r_sum #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(p_valid),
    .ready_o(p_ready),
    .op_i   (p_op),
    .x_i    (p_x),
    .y_i    (p_y),
    .z_i    (p_z),
    .ac_i   (p_ac),
    .bs_i   (p_bs),
    .as_i   (p_as),
    .bc_i   (p_bc),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .x_o    (x_out),
    .y_o    (y_out),
    .z_o    (z_out)
  );

  if (MPadW > 0) begin : g_pad
    assign m_axis_tdata = {{MPadW{1'b0}}, z_out, y_out, x_out};
  end else begin : g_nopad
    assign m_axis_tdata = {z_out, y_out, x_out};
  end

endmodule

FILE: src/vec3r_checker.sv
// port-level checker for the rotation pipeline, bound to the top level
`include "vec3_axis_rotation_defines.svh"

module vec3r_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     s_axis_tvalid,
  input logic                                     s_axis_tready,
  input logic                                     m_axis_tvalid,
  input logic                                     m_axis_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);

  logic s_xfer;
  logic m_stall;

  assign s_xfer  = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // stalled output keeps its valid and its data
  `VEC3R_ASSERT_NEXT(a_out_valid_held, m_stall, m_axis_tvalid)
  `VEC3R_ASSERT_NEXT(a_out_data_held, m_stall, $stable(m_axis_tdata))

  // an empty output stage means the whole pipeline can take a transfer
  `VEC3R_ASSERT_NOW(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready)

  // an accepted transfer reaches the output while the receiver keeps taking
  `VEC3R_ASSERT_NEXT(a_latency_three,
                     (s_xfer && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready,
                     m_axis_tvalid)

endmodule

bind vec3_axis_rotation vec3r_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_vec3r_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

FILE: sim/testbench.sv
// self-checking stream testbench for the principal-axis point rotation block
module testbench;

  localparam int COORD_W    = 32;
  localparam int INDEX_BITS = 10;
  localparam int STEPS      = 1 << INDEX_BITS;
  localparam int PHASE_W    = INDEX_BITS + 2;
  localparam int ANGLE_W    = vec3r_pkg::ANGLE_BITS;
  localparam int MAG_W      = vec3r_pkg::MAG_BITS;
  localparam int IN_W       = ((3*COORD_W+ANGLE_W+7)/8)*8;
  localparam int OUT_W      = ((3*COORD_W+7)/8)*8;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    vec3r_pkg::op_e     op;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [ANGLE_W-1:0] angle;
  } vertex_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [IN_W-1:0]                 s_axis_tdata = '0;
  logic [vec3r_pkg::OP_BITS-1:0]   s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [OUT_W-1:0]                m_axis_tdata;

  logic [MAG_W-1:0] sine_quarter [0:STEPS];

  vertex_t vertex_q [$];
  point_t  rotated_q [$];
  vertex_t staged;
  vertex_t seen_in;
  point_t  seen_out;
  point_t  want_out;

  logic in_fire = 1'b0;
  int   send_idle = 28;
  int   recv_idle = 86;
  int   total_items = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   op_count [4] = '{0, 0, 0, 0};

  vec3_axis_rotation #(
    .COORD_WIDTH    (COORD_W),
    .SINE_INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // quarter-wave q0.15 magnitude, taylor series in q30
  function automatic logic [MAG_W-1:0] sine_magnitude(int k);
    logic [63:0]        arg;
    logic [63:0]        arg_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic signed [63:0] rounded;
    int                 n;
    arg    = (vec3r_pkg::HALF_PI_Q30 * 64'(k)) / 64'(STEPS);
    arg_sq = (arg * arg) >> 30;
    term   = arg;
    acc    = $signed(arg);
    for (n = 1; n < 20 && term != 64'd0; n++) begin
      term = ((term * arg_sq) >> 30) / 64'(2*n*(2*n+1));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (acc + 64'sd16384) >>> 15;
    if (rounded > 64'sd32767) begin
      rounded = 64'sd32767;
    end
    return MAG_W'(rounded);
  endfunction

  function automatic logic signed [15:0] trig_q15(logic [PHASE_W-1:0] phase);
    logic [1:0] quadrant;
    int         idx;
    int         mag;
    quadrant = phase[PHASE_W-1 -: 2];
    idx      = int'(phase[INDEX_BITS-1:0]);
    mag      = quadrant[0] ? int'(sine_quarter[STEPS-idx]) : int'(sine_quarter[idx]);
    if (quadrant[1]) begin
      mag = -mag;
    end
    return 16'(mag);
  endfunction

  // coordinate times trig value, halves rounded upwards, then down by 15
  function automatic logic signed [63:0] scaled(coord_t a, logic signed [15:0] t);
    logic signed [63:0] wide_a;
    logic signed [63:0] wide_t;
    wide_a = a;
    wide_t = t;
    return (wide_a * wide_t + 64'sd16384) >>> vec3r_pkg::FRAC_SHIFT;
  endfunction

  function automatic coord_t clamp_coord(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = C_MAX;
    lo = C_MIN;
    if (v > hi) begin
      return C_MAX;
    end else if (v < lo) begin
      return C_MIN;
    end
    return coord_t'(v);
  endfunction

  function automatic point_t rotate_vertex(vertex_t v);
    logic [PHASE_W-1:0]  phase;
    logic [PHASE_W-1:0]  cos_phase;
    logic signed [15:0]  sn;
    logic signed [15:0]  cs;
    point_t              r;
    phase     = v.angle[ANGLE_W-1 -: PHASE_W];
    cos_phase = phase + PHASE_W'(STEPS);
    sn        = trig_q15(phase);
    cs        = trig_q15(cos_phase);
    r.x = v.x;
    r.y = v.y;
    r.z = v.z;
    case (v.op)
      vec3r_pkg::OP_ROT_X: begin
        r.y = clamp_coord(scaled(v.y, cs) - scaled(v.z, sn));
        r.z = clamp_coord(scaled(v.y, sn) + scaled(v.z, cs));
      end
      vec3r_pkg::OP_ROT_Y: begin
        r.x = clamp_coord(scaled(v.x, cs) - scaled(v.z, sn));
        r.z = clamp_coord(scaled(v.x, sn) + scaled(v.z, cs));
      end
      vec3r_pkg::OP_ROT_Z: begin
        r.x = clamp_coord(scaled(v.x, cs) - scaled(v.y, sn));
        r.y = clamp_coord(scaled(v.x, sn) + scaled(v.y, cs));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          3:       return '1;
          default: return coord_t'(1);
        endcase
      end
      1, 2, 3: return coord_t'(int'($urandom_range(0, 16777216)) - 8388608);
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic add_vertex(vec3r_pkg::op_e op, coord_t x, coord_t y, coord_t z,
                            logic [ANGLE_W-1:0] angle);
    vertex_t v;
    v.op    = op;
    v.x     = x;
    v.y     = y;
    v.z     = z;
    v.angle = angle;
    vertex_q.push_back(v);
  endtask

  // sender and receiver, driven on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (vertex_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          staged = vertex_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_W'({staged.angle, staged.z, staged.y, staged.x});
          s_axis_tuser  <= staged.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      seen_in.op    = vec3r_pkg::op_e'(s_axis_tuser);
      seen_in.x     = s_axis_tdata[0 +: COORD_W];
      seen_in.y     = s_axis_tdata[COORD_W +: COORD_W];
      seen_in.z     = s_axis_tdata[2*COORD_W +: COORD_W];
      seen_in.angle = s_axis_tdata[3*COORD_W +: ANGLE_W];
      rotated_q.push_back(rotate_vertex(seen_in));
      op_count[s_axis_tuser]++;
      n_in++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      seen_out.x = m_axis_tdata[0 +: COORD_W];
      seen_out.y = m_axis_tdata[COORD_W +: COORD_W];
      seen_out.z = m_axis_tdata[2*COORD_W +: COORD_W];
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected output transfer x=%h y=%h z=%h", $time,
                 seen_out.x, seen_out.y, seen_out.z);
        errors++;
      end else begin
        want_out = rotated_q.pop_front();
        if (seen_out !== want_out) begin
          $display("%0t: mismatch, expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                   $time, want_out.x, want_out.y, want_out.z,
                   seen_out.x, seen_out.y, seen_out.z);
          errors++;
        end
      end
      n_out++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d transfers in, %0d out", $time,
               n_in, total_items, n_out);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    vertex_t v;
    for (int k = 0; k <= STEPS; k++) begin
      sine_quarter[k] = sine_magnitude(k);
    end

    // zero angle on each axis with extreme coordinates
    add_vertex(vec3r_pkg::OP_ROT_X, C_MAX, C_MIN, coord_t'(1), 16'h0000);
    add_vertex(vec3r_pkg::OP_ROT_Y, C_MAX, C_MIN, coord_t'(1), 16'h0000);
    add_vertex(vec3r_pkg::OP_ROT_Z, C_MAX, C_MIN, coord_t'(1), 16'h0000);
    // quadrant boundaries
    add_vertex(vec3r_pkg::OP_ROT_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000);
    add_vertex(vec3r_pkg::OP_ROT_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h8000);
    add_vertex(vec3r_pkg::OP_ROT_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'hC000);
    add_vertex(vec3r_pkg::OP_ROT_Y, '1, '0, C_MAX, 16'hFFFF);
    // angle bits below the table resolution
    add_vertex(vec3r_pkg::OP_ROT_X, 32'h1234_5678, 32'h0040_0000, 32'hFFC0_0000, 16'h000F);
    // saturation, both signs
    add_vertex(vec3r_pkg::OP_ROT_Z, C_MAX, C_MAX, '0, 16'h2000);
    add_vertex(vec3r_pkg::OP_ROT_Z, C_MIN, C_MIN, '0, 16'h2000);
    add_vertex(vec3r_pkg::OP_ROT_X, '0, C_MAX, C_MIN, 16'h2000);
    add_vertex(vec3r_pkg::OP_ROT_Y, C_MIN, '0, C_MAX, 16'hE000);
    // products landing exactly on a half
    add_vertex(vec3r_pkg::OP_ROT_Z, coord_t'(16384), coord_t'(-16384), '0, 16'h0000);
    add_vertex(vec3r_pkg::OP_ROT_X, '0, coord_t'(-16384), coord_t'(16384), 16'h4000);
    // unused selector passes the point through
    add_vertex(vec3r_pkg::OP_PASS, C_MAX, C_MIN, 32'h5A5A_A5A5, 16'h1234);
    add_vertex(vec3r_pkg::OP_PASS, '0, '1, coord_t'(1), 16'hFFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      v.x     = random_coord();
      v.y     = random_coord();
      v.z     = random_coord();
      v.angle = ANGLE_W'($urandom());
      case ($urandom_range(0, 9))
        0, 1, 2: v.op = vec3r_pkg::OP_ROT_X;
        3, 4, 5: v.op = vec3r_pkg::OP_ROT_Y;
        6, 7, 8: v.op = vec3r_pkg::OP_ROT_Z;
        default: v.op = vec3r_pkg::OP_PASS;
      endcase
      vertex_q.push_back(v);
    end
    total_items = vertex_q.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (n_in >= total_items / 3);
    send_idle = 86;
    recv_idle = 28;
    wait (n_in >= 2 * total_items / 3);
    send_idle = 0;
    recv_idle = 0;
    wait (n_in == total_items);
    while (rotated_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    $display("%0d points checked: %0d about x, %0d about y, %0d about z, %0d passed through",
             n_out, op_count[vec3r_pkg::OP_ROT_X], op_count[vec3r_pkg::OP_ROT_Y],
             op_count[vec3r_pkg::OP_ROT_Z], op_count[vec3r_pkg::OP_PASS]);
    $display("idle mixes: sender-light, receiver-light and none; %0d errors", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/vec3r_pkg.sv
src/vec3r_trig.sv
src/vec3r_mult.sv
src/vec3r_sum.sv
src/vec3_axis_rotation.sv
src/vec3r_checker.sv
sim/testbench.sv
